### design/crcpd_pkg.sv
// ----------------------------------------------------------------------------
// crcpd_pkg: shared types and constants for the packet deframer
// Holds the frame phase and event codes, counter slots, CSR indexes and
// the CRC polynomial.
// ----------------------------------------------------------------------------
package crcpd_pkg;

   typedef enum logic [2:0] {
      PH_SOF1 = 3'd0,
      PH_SOF2 = 3'd1,
      PH_LEN  = 3'd2,
      PH_TYPE = 3'd3,
      PH_PAY  = 3'd4,
      PH_CLO  = 3'd5,
      PH_CHI  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_DISCARD   = 3'd0,
      EV_FRAMING   = 3'd1,
      EV_PAYLOAD   = 3'd2,
      EV_GOOD      = 3'd3,
      EV_CRC_BAD   = 3'd4,
      EV_END_CLEAN = 3'd5,
      EV_END_PART  = 3'd6
   } event_type;

   // counter slots
   localparam int CNT_DISC  = 0;
   localparam int CNT_SYNC  = 1;
   localparam int CNT_GOOD  = 2;
   localparam int CNT_CFAIL = 3;
   localparam int CNT_PART  = 4;
   localparam int CNT_NUM   = 5;

   // register indexes
   localparam logic [1:0] CSR_START_ONE = 2'd0;
   localparam logic [1:0] CSR_START_TWO = 2'd1;
   localparam logic [1:0] CSR_CRC_SEED  = 2'd2;

   localparam logic [7:0]  START_ONE_RESET = 8'hAA;
   localparam logic [7:0]  START_TWO_RESET = 8'h55;
   localparam logic [15:0] CRC_SEED_RESET  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'h1021;

   // counter increment requests for one transfer
   typedef struct packed {
      logic part;
      logic cfail;
      logic good;
      logic sync;
      logic disc;
   } bump_type;

endpackage

### design/crcpd_crc.sv
// ----------------------------------------------------------------------------
// crcpd_crc: byte-wide CRC-16 CCITT update
// Folds one byte into the running CRC, MSB first, no reflection.
// ----------------------------------------------------------------------------
module crcpd_crc (
   input  logic [15:0] crc_i,
   input  logic [7:0]  byte_i,
   output logic [15:0] crc_o
);

   always_comb begin
      logic [15:0] c;
      c = crc_i ^ {byte_i, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ crcpd_pkg::CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_o = c;
   end

endmodule

### design/crcpd_counters.sv
// ----------------------------------------------------------------------------
// crcpd_counters: bank of saturating statistic counters
// Each counter advances on its request bit and holds at all ones.
// ----------------------------------------------------------------------------
module crcpd_counters #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  crcpd_pkg::bump_type                           bump_i,
   output logic [crcpd_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0] count_o
);

   logic [crcpd_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0] count_ff;
   logic [crcpd_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0] count_in;
   logic [crcpd_pkg::CNT_NUM-1:0]                  req;

   assign req = bump_i;

   always_comb begin
      for (int k = 0; k < crcpd_pkg::CNT_NUM; k++) begin
         count_in[k] = count_ff[k];
         if (req[k] && (count_ff[k] != {COUNT_WIDTH{1'b1}})) begin
            count_in[k] = count_ff[k] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_o = count_ff;

endmodule

### design/crc_checked_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer: CRC-16 checked UART packet deframer
// rsp_valid is registered and is set in the cycle after an accepted req_ transfer.
// Throughput: one item per cycle while the result channel is not stalled; the byte-wide CRC update and frame phase
//   logic sit between the request handshake and the result register.
// Reset: synchronous, active high; clears phase, frame state and counters,
//   and loads the CSRs with their defaults.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_byte_out,
   output logic [7:0]  rsp_packet_type,
   output logic [7:0]  rsp_packet_length,
   output logic [7:0]  rsp_byte_position,
   output logic [31:0] rsp_discarded_total,
   output logic [31:0] rsp_sync_loss_total,
   output logic [31:0] rsp_good_total,
   output logic [31:0] rsp_crc_fail_total,
   output logic [31:0] rsp_partial_total,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers; out-of-range indexes are dropped.
   // ---------------------------------------------------------------------
   logic [7:0]  start_one_ff;
   logic [7:0]  start_two_ff;
   logic [15:0] crc_seed_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_one_ff <= crcpd_pkg::START_ONE_RESET;
         start_two_ff <= crcpd_pkg::START_TWO_RESET;
         crc_seed_ff  <= crcpd_pkg::CRC_SEED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crcpd_pkg::CSR_START_ONE: start_one_ff <= csr_data[7:0];
            crcpd_pkg::CSR_START_TWO: start_two_ff <= csr_data[7:0];
            crcpd_pkg::CSR_CRC_SEED:  crc_seed_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: take a new transfer whenever the result register is empty
   // or is being drained in this cycle.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------------------
   // Frame state
   // ---------------------------------------------------------------------
   crcpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic        in_flight_ff, in_flight_in;

   // result register payload
   crcpd_pkg::event_type event_ff, event_in;
   logic [7:0] byte_out_ff, byte_out_in;
   logic [7:0] type_out_ff, type_out_in;
   logic [7:0] len_out_ff, len_out_in;
   logic [7:0] pos_ff, pos_in;

   crcpd_pkg::bump_type bump;
   logic [15:0]         crc_next;
   logic [7:0]          count_inc;

   crcpd_crc u_crc (
      .crc_i  (crc_ff),
      .byte_i (req_data_byte),
      .crc_o  (crc_next)
   );

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      type_in      = type_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      crc_lo_in    = crc_lo_ff;
      in_flight_in = in_flight_ff;
      event_in     = crcpd_pkg::EV_DISCARD;
      byte_out_in  = 8'd0;
      pos_in       = 8'd0;
      bump         = '0;

      if (req_kind) begin
         // end of stream: report, then return frame state to reset values
         if ((phase_ff != crcpd_pkg::PH_SOF1) && (phase_ff <= crcpd_pkg::PH_CHI)) begin
            event_in  = crcpd_pkg::EV_END_PART;
            bump.part = 1'b1;
         end else begin
            event_in = crcpd_pkg::EV_END_CLEAN;
         end
         phase_in     = crcpd_pkg::PH_SOF1;
         len_in       = 8'd0;
         type_in      = 8'd0;
         count_in     = 8'd0;
         crc_in       = 16'd0;
         crc_lo_in    = 8'd0;
         in_flight_in = 1'b0;
      end else begin
         case (phase_ff)
            crcpd_pkg::PH_SOF2: begin
               // second-byte match wins when both start bytes are equal
               if (req_data_byte == start_two_ff) begin
                  phase_in     = crcpd_pkg::PH_LEN;
                  in_flight_in = 1'b1;
                  event_in     = crcpd_pkg::EV_FRAMING;
               end else if (req_data_byte == start_one_ff) begin
                  bump.disc = 1'b1;
               end else begin
                  bump.disc = 1'b1;
                  phase_in  = crcpd_pkg::PH_SOF1;
               end
            end
            crcpd_pkg::PH_LEN: begin
               len_in   = req_data_byte;
               count_in = 8'd0;
               crc_in   = crc_seed_ff;
               phase_in = crcpd_pkg::PH_TYPE;
               event_in = crcpd_pkg::EV_FRAMING;
            end
            crcpd_pkg::PH_TYPE: begin
               type_in  = req_data_byte;
               crc_in   = crc_next;
               phase_in = (len_ff == 8'd0) ? crcpd_pkg::PH_CLO : crcpd_pkg::PH_PAY;
               event_in = crcpd_pkg::EV_FRAMING;
            end
            crcpd_pkg::PH_PAY: begin
               event_in    = crcpd_pkg::EV_PAYLOAD;
               byte_out_in = req_data_byte;
               pos_in      = count_ff;
               crc_in      = crc_next;
               count_in    = count_inc;
               if (count_inc >= len_ff) begin
                  phase_in = crcpd_pkg::PH_CLO;
               end
            end
            crcpd_pkg::PH_CLO: begin
               crc_lo_in = req_data_byte;
               phase_in  = crcpd_pkg::PH_CHI;
               event_in  = crcpd_pkg::EV_FRAMING;
            end
            crcpd_pkg::PH_CHI: begin
               // CRC arrives low byte first; commit or drop the packet
               if ({req_data_byte, crc_lo_ff} == crc_ff) begin
                  bump.good = 1'b1;
                  event_in  = crcpd_pkg::EV_GOOD;
               end else begin
                  bump.cfail = 1'b1;
                  bump.sync  = in_flight_ff;
                  event_in   = crcpd_pkg::EV_CRC_BAD;
               end
               phase_in     = crcpd_pkg::PH_SOF1;
               in_flight_in = 1'b0;
               count_in     = 8'd0;
            end
            default: begin
               // hunting the first start byte; unused codes land here too
               phase_in = crcpd_pkg::PH_SOF1;
               if (req_data_byte == start_one_ff) begin
                  phase_in = crcpd_pkg::PH_SOF2;
                  event_in = crcpd_pkg::EV_FRAMING;
               end else begin
                  bump.disc = 1'b1;
               end
            end
         endcase
      end

      // end of stream reports the held values from before the clear
      type_out_in = req_kind ? type_ff : type_in;
      len_out_in  = req_kind ? len_ff  : len_in;

      // only a real transfer moves state or counters
      if (!accept) begin
         bump = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= crcpd_pkg::PH_SOF1;
         len_ff       <= 8'd0;
         type_ff      <= 8'd0;
         count_ff     <= 8'd0;
         crc_ff       <= 16'd0;
         crc_lo_ff    <= 8'd0;
         in_flight_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            len_ff       <= len_in;
            type_ff      <= type_in;
            count_ff     <= count_in;
            crc_ff       <= crc_in;
            crc_lo_ff    <= crc_lo_in;
            in_flight_ff <= in_flight_in;
         end
      end
   end

   // result payload: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff    <= event_in;
         byte_out_ff <= byte_out_in;
         type_out_ff <= type_out_in;
         len_out_ff  <= len_out_in;
         pos_ff      <= pos_in;
      end
   end

   // ---------------------------------------------------------------------
   // Statistic counters. They change only on an accepted transfer, so the
   // registers always show the values after the item held in the result
   // register.
   // ---------------------------------------------------------------------
   logic [crcpd_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0] counts;

   crcpd_counters #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counters (
      .clock   (clock),
      .reset   (reset),
      .bump_i  (bump),
      .count_o (counts)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = event_ff;
   assign rsp_byte_out        = byte_out_ff;
   assign rsp_packet_type     = type_out_ff;
   assign rsp_packet_length   = len_out_ff;
   assign rsp_byte_position   = pos_ff;
   assign rsp_discarded_total = 32'(counts[crcpd_pkg::CNT_DISC]);
   assign rsp_sync_loss_total = 32'(counts[crcpd_pkg::CNT_SYNC]);
   assign rsp_good_total      = 32'(counts[crcpd_pkg::CNT_GOOD]);
   assign rsp_crc_fail_total  = 32'(counts[crcpd_pkg::CNT_CFAIL]);
   assign rsp_partial_total   = 32'(counts[crcpd_pkg::CNT_PART]);

endmodule

### design/crcpd_checker.sv
// ----------------------------------------------------------------------------
// crcpd_checker: port-level assertions for the packet deframer
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module crcpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_byte_out,
   input logic [7:0]  rsp_packet_length,
   input logic [7:0]  rsp_byte_position
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_byte_out) && $stable(rsp_byte_position))
      else $error("stalled result changed");

   // request side stalls only behind a waiting result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a waiting result");

   // a new result needs an accepted request transfer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without a request transfer");

   // payload index stays inside the packet length
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == crcpd_pkg::EV_PAYLOAD)
         |-> rsp_byte_position < rsp_packet_length)
      else $error("payload position beyond packet length");

endmodule

bind crc_checked_packet_deframer crcpd_checker u_crcpd_checker (.*);

### sim/tb_crc_checked_packet_deframer.sv
// ----------------------------------------------------------------------------
// tb_crc_checked_packet_deframer: self-checking bench for the packet deframer
// Drives UART bytes and end-of-stream marks through the request channel.
// Predicts every result event with a bench-side deframer and CRC-16 CCITT
// engine. Compares each result transfer field by field against the oldest
// prediction. Sender bursts and receiver stalls are randomized, and the
// start bytes and CRC seed are reprogrammed between traffic phases.
// ----------------------------------------------------------------------------
module tb_crc_checked_packet_deframer;

   localparam logic       KIND_BYTE    = 1'b0;
   localparam logic       KIND_END     = 1'b1;
   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam int         LIMIT_CYCLES = 400000;
   localparam int         RANDOM_ITEMS = 640;

   // one predicted result transfer
   typedef struct packed {
      crcpd_pkg::event_type ev;
      logic [7:0]  bout;
      logic [7:0]  ptype;
      logic [7:0]  plen;
      logic [7:0]  pos;
      logic [31:0] disc;
      logic [31:0] sync;
      logic [31:0] good;
      logic [31:0] cfail;
      logic [31:0] part;
   } deframe_result_type;

   // DUT ports; every input is driven to a known value from time zero
   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_kind      = KIND_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_byte_out;
   logic [7:0]  rsp_packet_type;
   logic [7:0]  rsp_packet_length;
   logic [7:0]  rsp_byte_position;
   logic [31:0] rsp_discarded_total;
   logic [31:0] rsp_sync_loss_total;
   logic [31:0] rsp_good_total;
   logic [31:0] rsp_crc_fail_total;
   logic [31:0] rsp_partial_total;
   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index     = crcpd_pkg::CSR_START_ONE;
   logic [15:0] csr_data      = 16'h0000;

   // bench copy of the CSRs
   logic [7:0]  start_one  = crcpd_pkg::START_ONE_RESET;
   logic [7:0]  start_two  = crcpd_pkg::START_TWO_RESET;
   logic [15:0] seed_value = crcpd_pkg::CRC_SEED_RESET;

   // bench copy of the deframer state
   crcpd_pkg::phase_type frame_phase = crcpd_pkg::PH_SOF1;
   logic [7:0]  held_len    = 8'h00;
   logic [7:0]  held_type   = 8'h00;
   logic [7:0]  pay_count   = 8'h00;
   logic [15:0] crc_acc     = 16'h0000;
   logic [7:0]  crc_lo      = 8'h00;
   logic        in_flight   = 1'b0;
   logic [31:0] stat_count [crcpd_pkg::CNT_NUM] = '{default: '0};

   deframe_result_type pending_events [$];
   int              errors      = 0;
   int              items_sent  = 0;
   int              burst_left  = 0;
   int unsigned     cycle_count = 0;

   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_left  = 0;

   crc_checked_packet_deframer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_packet_type     (rsp_packet_type),
      .rsp_packet_length   (rsp_packet_length),
      .rsp_byte_position   (rsp_byte_position),
      .rsp_discarded_total (rsp_discarded_total),
      .rsp_sync_loss_total (rsp_sync_loss_total),
      .rsp_good_total      (rsp_good_total),
      .rsp_crc_fail_total  (rsp_crc_fail_total),
      .rsp_partial_total   (rsp_partial_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // one byte through CRC-16 CCITT, MSB first, no reflection
   function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                    input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ crcpd_pkg::CRC_POLY) : (c << 1);
      return c;
   endfunction

   // saturating statistics counter
   function automatic void bump_count(input int slot);
      if (stat_count[slot] != '1)
         stat_count[slot] = stat_count[slot] + 32'd1;
   endfunction

   // advance the bench deframer by one accepted item and return its event
   function automatic deframe_result_type deframe_byte(input logic kind,
                                                       input logic [7:0] b);
      deframe_result_type r;
      r    = '0;
      r.ev = crcpd_pkg::EV_DISCARD;
      if (kind == KIND_END) begin
         // anything past the first start byte hunt counts as a partial end
         if (frame_phase != crcpd_pkg::PH_SOF1) begin
            r.ev = crcpd_pkg::EV_END_PART;
            bump_count(crcpd_pkg::CNT_PART);
         end else begin
            r.ev = crcpd_pkg::EV_END_CLEAN;
         end
         r.ptype = held_type;
         r.plen  = held_len;
         // drop all frame state, keep the counters
         frame_phase = crcpd_pkg::PH_SOF1;
         held_len    = 8'h00;
         held_type   = 8'h00;
         pay_count   = 8'h00;
         crc_acc     = 16'h0000;
         crc_lo      = 8'h00;
         in_flight   = 1'b0;
      end else begin
         case (frame_phase)
            crcpd_pkg::PH_SOF2: begin
               // second-byte match wins when both start bytes are equal
               if (b == start_two) begin
                  frame_phase = crcpd_pkg::PH_LEN;
                  in_flight   = 1'b1;
                  r.ev        = crcpd_pkg::EV_FRAMING;
               end else if (b == start_one) begin
                  bump_count(crcpd_pkg::CNT_DISC);
               end else begin
                  bump_count(crcpd_pkg::CNT_DISC);
                  frame_phase = crcpd_pkg::PH_SOF1;
               end
            end
            crcpd_pkg::PH_LEN: begin
               held_len    = b;
               pay_count   = 8'h00;
               crc_acc     = seed_value;
               frame_phase = crcpd_pkg::PH_TYPE;
               r.ev        = crcpd_pkg::EV_FRAMING;
            end
            crcpd_pkg::PH_TYPE: begin
               held_type   = b;
               crc_acc     = crc16_ccitt_byte(crc_acc, b);
               frame_phase = (held_len == 8'h00) ? crcpd_pkg::PH_CLO : crcpd_pkg::PH_PAY;
               r.ev        = crcpd_pkg::EV_FRAMING;
            end
            crcpd_pkg::PH_PAY: begin
               r.ev      = crcpd_pkg::EV_PAYLOAD;
               r.bout    = b;
               r.pos     = pay_count;
               crc_acc   = crc16_ccitt_byte(crc_acc, b);
               pay_count = pay_count + 8'd1;
               if (pay_count >= held_len)
                  frame_phase = crcpd_pkg::PH_CLO;
            end
            crcpd_pkg::PH_CLO: begin
               crc_lo      = b;
               frame_phase = crcpd_pkg::PH_CHI;
               r.ev        = crcpd_pkg::EV_FRAMING;
            end
            crcpd_pkg::PH_CHI: begin
               if ({b, crc_lo} == crc_acc) begin
                  bump_count(crcpd_pkg::CNT_GOOD);
                  r.ev = crcpd_pkg::EV_GOOD;
               end else begin
                  bump_count(crcpd_pkg::CNT_CFAIL);
                  if (in_flight)
                     bump_count(crcpd_pkg::CNT_SYNC);
                  r.ev = crcpd_pkg::EV_CRC_BAD;
               end
               frame_phase = crcpd_pkg::PH_SOF1;
               in_flight   = 1'b0;
               pay_count   = 8'h00;
            end
            default: begin
               frame_phase = crcpd_pkg::PH_SOF1;
               if (b == start_one) begin
                  frame_phase = crcpd_pkg::PH_SOF2;
                  r.ev        = crcpd_pkg::EV_FRAMING;
               end else begin
                  bump_count(crcpd_pkg::CNT_DISC);
               end
            end
         endcase
         r.ptype = held_type;
         r.plen  = held_len;
      end
      r.disc  = stat_count[crcpd_pkg::CNT_DISC];
      r.sync  = stat_count[crcpd_pkg::CNT_SYNC];
      r.good  = stat_count[crcpd_pkg::CNT_GOOD];
      r.cfail = stat_count[crcpd_pkg::CNT_CFAIL];
      r.part  = stat_count[crcpd_pkg::CNT_PART];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: receiver stall pattern and checker
   // ---------------------------------------------------------------------

   // Rotate a 16-bit ready pattern; swap in a fresh one now and then. Bit 0
   // is forced high on both random patterns and no pattern is all zeros, so the channel never locks up.
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_pattern <= 16'hFFFF;
            1:       ready_pattern <= 16'($urandom()) | 16'h0001;
            2:       ready_pattern <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
            default: ready_pattern <= 16'hFFFE;
         endcase
         pattern_left <= $urandom_range(16, 200);
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         pattern_left  <= pattern_left - 1;
      end
      rsp_ready <= ready_pattern[0];
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : compare_results
      deframe_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, got event %0d",
                     $time, rsp_event_res);
            errors++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_res",       32'(want.ev),    32'(rsp_event_res));
            check_field("byte_out",        32'(want.bout),  32'(rsp_byte_out));
            check_field("packet_type",     32'(want.ptype), 32'(rsp_packet_type));
            check_field("packet_length",   32'(want.plen),  32'(rsp_packet_length));
            check_field("byte_position",   32'(want.pos),   32'(rsp_byte_position));
            check_field("discarded_total", want.disc,  rsp_discarded_total);
            check_field("sync_loss_total", want.sync,  rsp_sync_loss_total);
            check_field("good_total",      want.good,  rsp_good_total);
            check_field("crc_fail_total",  want.cfail, rsp_crc_fail_total);
            check_field("partial_total",   want.part,  rsp_partial_total);
         end
      end
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_crc_checked_packet_deframer: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Send one item and hold it until the transfer. Predict at the accepting
   // edge. When a burst runs out, drop valid for a random gap, so valid is never
   // lowered and raised in the same step.
   task automatic send_item(input logic kind, input logic [7:0] b);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      pending_events.push_back(deframe_byte(kind, b));
      items_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   // Build a frame from the current CSR copy and send the first cut bytes
   // of it (all of it when cut is negative or too large). Corrupt flips one CRC bit.
   task automatic send_frame(input int len, input logic [7:0] ptype,
                             input bit corrupt, input int cut);
      logic [7:0]  frame_bytes [$];
      logic [15:0] crc;
      logic [7:0]  b;
      frame_bytes = {start_one, start_two, 8'(len), ptype};
      crc         = crc16_ccitt_byte(seed_value, ptype);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         frame_bytes.push_back(b);
         crc = crc16_ccitt_byte(crc, b);
      end
      if (corrupt)
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      if (cut < 0 || cut > frame_bytes.size())
         cut = frame_bytes.size();
      for (int i = 0; i < cut; i++)
         send_item(KIND_BYTE, frame_bytes[i]);
   endtask

   // Drop valid and wait until every predicted result has been checked.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write one CSR; only call this with the deframer drained.
   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         crcpd_pkg::CSR_START_ONE: start_one  = value[7:0];
         crcpd_pkg::CSR_START_TWO: start_two  = value[7:0];
         crcpd_pkg::CSR_CRC_SEED:  seed_value = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Short directed pass with the reset CSR values.
   task automatic test_framing_basics();
      send_item(KIND_END, 8'hFF);                  // clean end while hunting
      send_item(KIND_BYTE, 8'h00);                 // noise byte
      send_item(KIND_BYTE, start_one);             // repeated first start byte
      send_frame(0, 8'hFF, 1'b0, -1);              // zero length, good CRC
      send_item(KIND_BYTE, start_one);
      send_item(KIND_BYTE, 8'h12);                 // wrong second start byte
      send_frame(2, 8'h00, 1'b1, -1);              // payload, bad CRC
      send_item(KIND_BYTE, start_one);
      send_item(KIND_END, 8'h00);                  // end while hunting second byte
      send_frame(3, 8'h5A, 1'b0, 3);               // stop right after the length
      send_item(KIND_END, 8'h80);
   endtask

   // Corner CSR values: zero and all-ones bytes, equal start bytes, zero seed,
   // junk in the upper data bits, and a write to the unused index.
   task automatic test_register_extremes();
      wait_until_drained();
      write_register(crcpd_pkg::CSR_START_ONE, 16'hFF00);
      write_register(crcpd_pkg::CSR_START_TWO, 16'h00FF);
      write_register(crcpd_pkg::CSR_CRC_SEED,  16'h0000);
      write_register(CSR_UNUSED,               16'hFFFF);
      send_frame(255, 8'hFF, 1'b0, -1);            // longest payload
      send_frame(1, 8'h00, 1'b1, -1);
      send_item(KIND_BYTE, 8'hFF);                 // noise that is the second byte

      wait_until_drained();
      write_register(crcpd_pkg::CSR_START_ONE, 16'h00FF);
      write_register(crcpd_pkg::CSR_START_TWO, 16'hA5FF);
      write_register(crcpd_pkg::CSR_CRC_SEED,  16'hFFFF);
      send_frame(0, 8'h33, 1'b0, -1);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, 8'hFF);                 // equal start bytes: second wins
      send_item(KIND_END, 8'h7F);
      send_frame(4, 8'hA5, 1'b0, -1);

      wait_until_drained();
      write_register(crcpd_pkg::CSR_START_ONE, 16'h00FF);
      write_register(crcpd_pkg::CSR_START_TWO, 16'h0000);
      write_register(crcpd_pkg::CSR_CRC_SEED,  16'h8000);
      send_frame(5, 8'h80, 1'b0, -1);
      send_frame(5, 8'h01, 1'b1, -1);

      wait_until_drained();
      write_register(crcpd_pkg::CSR_START_ONE, 16'(crcpd_pkg::START_ONE_RESET));
      write_register(crcpd_pkg::CSR_START_TWO, 16'(crcpd_pkg::START_TWO_RESET));
      write_register(crcpd_pkg::CSR_CRC_SEED,  crcpd_pkg::CRC_SEED_RESET);
   endtask

   // Reprogram CSRs with a frame half received: start bytes take effect
   // at once, the seed only at the next length byte.
   task automatic test_midpacket_register_change();
      wait_until_drained();
      send_item(KIND_BYTE, crcpd_pkg::START_ONE_RESET);
      wait_until_drained();
      write_register(crcpd_pkg::CSR_START_ONE, 16'h0011);
      send_item(KIND_BYTE, crcpd_pkg::START_ONE_RESET);   // no longer a start byte
      send_item(KIND_BYTE, 8'h11);
      wait_until_drained();
      write_register(crcpd_pkg::CSR_START_TWO, 16'h003C);
      send_item(KIND_BYTE, 8'h3C);
      send_item(KIND_BYTE, 8'd2);
      wait_until_drained();
      write_register(crcpd_pkg::CSR_CRC_SEED, 16'h1234);  // too late for this frame
      send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      // close the frame with the CRC the old seed produced
      send_item(KIND_BYTE, crc_acc[7:0]);
      send_item(KIND_BYTE, crc_acc[15:8]);
   endtask

   // Mostly well-formed frames with random content, plus truncated frames,
   // noise and end marks, in phases with fresh random CSR values.
   task automatic test_random_traffic(input int total);
      int stop_at;
      int len;
      int cut;
      int kind_pick;
      int size_pick;
      for (int p = 0; p < 4; p++) begin
         wait_until_drained();
         write_register(crcpd_pkg::CSR_START_ONE, 16'($urandom()));
         if ($urandom_range(0, 4) == 0)
            write_register(crcpd_pkg::CSR_START_TWO, {8'($urandom()), start_one});
         else
            write_register(crcpd_pkg::CSR_START_TWO, 16'($urandom()));
         write_register(crcpd_pkg::CSR_CRC_SEED, 16'($urandom()));
         write_register(CSR_UNUSED,              16'($urandom()));
         stop_at = items_sent + total / 4;
         while (items_sent < stop_at) begin
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 70) begin
               // mostly short payloads, some empty, a rare long one
               size_pick = $urandom_range(0, 99);
               if (size_pick < 2)
                  len = $urandom_range(200, 255);
               else if (size_pick < 15)
                  len = 0;
               else
                  len = $urandom_range(1, 12);
               send_frame(len, 8'($urandom()), $urandom_range(0, 9) == 0, -1);
            end else if (kind_pick < 80) begin
               len = $urandom_range(0, 10);
               cut = $urandom_range(1, len + 5);
               send_frame(len, 8'($urandom()), 1'b0, cut);
               if ($urandom_range(0, 1) == 0)
                  send_item(KIND_END, 8'($urandom()));
            end else if (kind_pick < 92) begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 3) == 0)
                     send_item(KIND_BYTE, $urandom_range(0, 1) ? start_one : start_two);
                  else
                     send_item(KIND_BYTE, 8'($urandom()));
               end
            end else begin
               send_item(KIND_END, 8'($urandom()));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_framing_basics();
      test_register_extremes();
      test_midpacket_register_change();
      test_random_traffic(RANDOM_ITEMS);

      // let the last results drain and catch any stray result before the verdict
      wait_until_drained();
      repeat (4) @(posedge clock);
      if (errors == 0 && pending_events.size() == 0)
         $display("tb_crc_checked_packet_deframer: done, clean");
      else
         $display("tb_crc_checked_packet_deframer: done, errors");
      $finish;
   end

endmodule
